/* hdl/gcj_pkg.sv */
`default_nettype none
package gcj_pkg;

  localparam int JUMP_CHARS_DEF = 15;
  localparam int COORD_BITS_DEF = 16;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CODE_W     = 6;
  localparam int LETTER_W   = 20;
  localparam int LETTER_LIMIT = 1000000;
  localparam int LETTER_BASE  = 26;
  localparam int DIGIT_BASE   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [2:0] MODE_CHAR  = 3'd0;
  localparam logic [2:0] MODE_UP    = 3'd1;
  localparam logic [2:0] MODE_DOWN  = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;
  localparam logic [2:0] MODE_ENTER = 3'd5;
  localparam logic [2:0] MODE_ESC   = 3'd6;
  localparam logic [2:0] MODE_BKSP  = 3'd7;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_MOVED  = 3'd1;
  localparam logic [2:0] ACT_BUF    = 3'd2;
  localparam logic [2:0] ACT_JUMPED = 3'd3;
  localparam logic [2:0] ACT_ENTER  = 3'd4;
  localparam logic [2:0] ACT_DISARM = 3'd5;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CHAR_D0 = 8'h30;
  localparam logic [7:0] CHAR_D9 = 8'h39;

  // letters encode as 0..25, digits as 26..35
  localparam logic [CODE_W-1:0] DIGIT_CODE0 = 6'd26;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic commit;
  } gcj_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic last_rd;
  } gcj_status_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } gcj_enc_t;

  function automatic gcj_enc_t gcj_encode(input logic [7:0] c);
    gcj_enc_t r;
    r.valid = 1'b1;
    r.code  = '0;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      r.code = CODE_W'(c - CHAR_UA);
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      r.code = CODE_W'(c - CHAR_LA);
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      r.code = CODE_W'(c - CHAR_D0) + DIGIT_CODE0;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/gcj_in_if.sv */
`default_nettype none
interface gcj_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] ch;

  modport source (output valid, output mode, output ch, input ready);
  modport sink (input valid, input mode, input ch, output ready);
endinterface
`default_nettype wire

/* hdl/gcj_out_if.sv */
`default_nettype none
interface gcj_out_if #(
  parameter int COORD_BITS = 16,
  parameter int LEN_W      = 4
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [COORD_BITS-1:0] cursor_row;
  logic [COORD_BITS-1:0] cursor_col;
  logic [LEN_W-1:0]      pending_length;

  modport source (output valid, output action, output cursor_row, output cursor_col,
                  output pending_length, input ready);
  modport sink (input valid, input action, input cursor_row, input cursor_col,
                input pending_length, output ready);
endinterface
`default_nettype wire

/* hdl/gcj_cfg_if.sv */
`default_nettype none
interface gcj_cfg_if import gcj_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/gcj_ctrl.sv */
`default_nettype none
module gcj_ctrl import gcj_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire gcj_status_t status,
  output gcj_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = status.scan_req ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.last_rd) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the finished request until the output register frees up
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/gcj_dp.sv */
`default_nettype none
module gcj_dp import gcj_pkg::*; #(
  parameter int JUMP_CHARS = JUMP_CHARS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LEN_W      = $clog2(JUMP_CHARS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [2:0]           in_mode,
  input  wire logic [7:0]           in_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire gcj_cmd_t             cmd,
  output gcj_status_t               status,
  output logic [2:0]                out_action,
  output logic [COORD_BITS-1:0]     out_cursor_row,
  output logic [COORD_BITS-1:0]     out_cursor_col,
  output logic [LEN_W-1:0]          out_pending_length
);

  localparam int IDX_W = $clog2(JUMP_CHARS);
  localparam int CM_W  = LETTER_W + 5;
  localparam int RM_W  = COORD_BITS + 5;
  localparam int CK_W  = ((COORD_BITS + 1 > LETTER_W) ? COORD_BITS + 1 : LETTER_W) + 1;
  localparam logic [COORD_BITS:0] ROW_SAT = (COORD_BITS + 1)'((1 << COORD_BITS) + 1);

  logic [2:0]            mode_r;
  logic [7:0]            ch_r;
  logic [CFG_W-1:0]      row_count_r, col_count_r;
  logic [COORD_BITS-1:0] cur_row_r, cur_col_r, cur_row_nxt, cur_col_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;

  logic [CODE_W-1:0]     mem [JUMP_CHARS];
  logic [CODE_W-1:0]     rdata_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  rd_pend_r;
  logic                  mem_we;

  logic [LETTER_W-1:0]   colv_r;
  logic [COORD_BITS:0]   rowv_r;
  logic                  has_let_r, has_dig_r, bad_r;

  logic                  is_letter;
  logic [CM_W-1:0]       col_mul;
  logic [RM_W-1:0]       row_mul;

  gcj_enc_t              enc;
  logic [CK_W-1:0]       colv_x, rowv_x, colv_m1, rowv_m1, coord_lim;
  logic                  jump_ok;
  logic [2:0]            action;

  assign status.scan_req = (mode_r == MODE_ENTER) && (len_r != '0);
  assign status.last_rd  = (LEN_W'(idx_r) == len_r - LEN_W'(1));

  // buffer walk: one entry read per cycle, folded in the cycle after
  assign is_letter = (rdata_r < DIGIT_CODE0);
  assign col_mul = CM_W'(colv_r) * CM_W'(LETTER_BASE) + CM_W'(rdata_r) + CM_W'(1);
  assign row_mul = RM_W'(rowv_r) * RM_W'(DIGIT_BASE) + RM_W'(rdata_r - DIGIT_CODE0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len_r[IDX_W-1:0]] <= enc.code;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r    <= in_mode;
      ch_r      <= in_ch;
      colv_r    <= '0;
      rowv_r    <= '0;
      has_let_r <= 1'b0;
      has_dig_r <= 1'b0;
      bad_r     <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cmd.rd_en) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (rd_pend_r) begin
        if (is_letter) begin
          has_let_r <= 1'b1;
          if (!bad_r) begin
            colv_r <= LETTER_W'(col_mul);
            if (col_mul > CM_W'(LETTER_LIMIT)) begin
              bad_r <= 1'b1;
            end
          end
        end else begin
          has_dig_r <= 1'b1;
          if (row_mul > (RM_W'(1) << COORD_BITS)) begin
            rowv_r <= ROW_SAT;
          end else begin
            rowv_r <= (COORD_BITS + 1)'(row_mul);
          end
        end
      end
    end
  end

  // cell check after the walk
  always_comb begin
    colv_x    = CK_W'(colv_r);
    rowv_x    = CK_W'(rowv_r);
    colv_m1   = colv_x - CK_W'(1);
    rowv_m1   = rowv_x - CK_W'(1);
    coord_lim = CK_W'(1) << COORD_BITS;
    jump_ok   = has_let_r && has_dig_r && !bad_r &&
                (colv_x <= coord_lim) && (rowv_x != '0) && (rowv_x <= coord_lim) &&
                !((row_count_r != '0) && (rowv_m1 >= CK_W'(row_count_r))) &&
                !((col_count_r != '0) && (colv_m1 >= CK_W'(col_count_r)));
  end

  always_comb begin
    enc         = gcj_encode(ch_r);
    action      = ACT_NONE;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    len_nxt     = len_r;
    mem_we      = 1'b0;
    unique case (mode_r)
      MODE_CHAR: begin
        if (enc.valid && (len_r < LEN_W'(JUMP_CHARS))) begin
          mem_we  = cmd.commit;
          len_nxt = len_r + LEN_W'(1);
          action  = ACT_BUF;
        end
      end
      MODE_UP: begin
        if (cur_row_r != '0) begin
          cur_row_nxt = cur_row_r - COORD_BITS'(1);
          action      = ACT_MOVED;
        end
      end
      MODE_DOWN: begin
        if (((row_count_r == '0) ||
             (CK_W'(cur_row_r) + CK_W'(1) < CK_W'(row_count_r))) && (cur_row_r != '1)) begin
          cur_row_nxt = cur_row_r + COORD_BITS'(1);
          action      = ACT_MOVED;
        end
      end
      MODE_LEFT: begin
        if (cur_col_r != '0) begin
          cur_col_nxt = cur_col_r - COORD_BITS'(1);
          action      = ACT_MOVED;
        end
      end
      MODE_RIGHT: begin
        if (((col_count_r == '0) ||
             (CK_W'(cur_col_r) + CK_W'(1) < CK_W'(col_count_r))) && (cur_col_r != '1)) begin
          cur_col_nxt = cur_col_r + COORD_BITS'(1);
          action      = ACT_MOVED;
        end
      end
      MODE_ENTER: begin
        if (len_r != '0) begin
          len_nxt = '0;
          if (jump_ok) begin
            cur_row_nxt = rowv_m1[COORD_BITS-1:0];
            cur_col_nxt = colv_m1[COORD_BITS-1:0];
            action      = ACT_JUMPED;
          end
        end else begin
          action = ACT_ENTER;
        end
      end
      MODE_ESC: begin
        action = ACT_DISARM;
      end
      MODE_BKSP: begin
        if (len_r != '0) begin
          len_nxt = len_r - LEN_W'(1);
          action  = ACT_BUF;
        end
      end
      default: begin
        action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action         <= action;
      out_cursor_row     <= cur_row_nxt;
      out_cursor_col     <= cur_col_nxt;
      out_pending_length <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      len_r       <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    row_count_r <= cfg_data;
          REG_COLUMN_COUNT: col_count_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        len_r     <= len_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/grid_cursor_jump_navigator.sv */
// Each request is accepted in idle, decoded in an execute state and committed to the result
// register from a finish state that waits until that register is free; enter with buffered
// characters adds a scan and a flush state. Throughput: one request at a time; the enter
// path walks the jump buffer memory, one entry per cycle through its registered read port.
// Reset (synchronous, rst_n low): cursor at 0/0, buffer empty, bounds 0, no result held.
`default_nettype none
module grid_cursor_jump_navigator import gcj_pkg::*; #(
  parameter int JUMP_CHARS = JUMP_CHARS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gcj_in_if.sink    in_ch,
  gcj_out_if.source out_ch,
  gcj_cfg_if.sink   cfg_ch
);

  localparam int LEN_W = $clog2(JUMP_CHARS + 1);

  gcj_cmd_t    cmd;
  gcj_status_t status;
  logic [LEN_W-1:0] pend_len;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.pending_length = pend_len;

  gcj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcj_dp #(
    .JUMP_CHARS (JUMP_CHARS),
    .COORD_BITS (COORD_BITS),
    .LEN_W      (LEN_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_ch.mode),
    .in_ch              (in_ch.ch),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .cmd                (cmd),
    .status             (status),
    .out_action         (out_ch.action),
    .out_cursor_row     (out_ch.cursor_row),
    .out_cursor_col     (out_ch.cursor_col),
    .out_pending_length (pend_len)
  );

endmodule
`default_nettype wire

/* hdl/gcj_checker.sv */
`default_nettype none
module gcj_checker import gcj_pkg::*; #(
  parameter int JUMP_CHARS = JUMP_CHARS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LEN_W      = $clog2(JUMP_CHARS + 1)
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [2:0]            out_action,
  input wire logic [COORD_BITS-1:0] out_cursor_row,
  input wire logic [COORD_BITS-1:0] out_cursor_col,
  input wire logic [LEN_W-1:0]      out_pending_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_action) && $stable(out_cursor_row) &&
                                $stable(out_cursor_col) && $stable(out_pending_length))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_length <= LEN_W'(JUMP_CHARS))
    else $error("pending length beyond buffer depth");

  a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_JUMPED || out_action == ACT_ENTER)
      |-> out_pending_length == '0)
    else $error("jump or enter-cell with a nonempty buffer");

endmodule

bind grid_cursor_jump_navigator gcj_checker #(
  .JUMP_CHARS (JUMP_CHARS),
  .COORD_BITS (COORD_BITS)
) u_gcj_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_action         (out_ch.action),
  .out_cursor_row     (out_ch.cursor_row),
  .out_cursor_col     (out_ch.cursor_col),
  .out_pending_length (out_ch.pending_length)
);
`default_nettype wire

/* sim/grid_cursor_jump_navigator_tb.sv */
`timescale 1ns / 1ps
import gcj_pkg::*;

typedef struct packed {
  logic [2:0]  action;
  logic [15:0] row;
  logic [15:0] col;
  logic [3:0]  held;
} cursor_report_t;

class cursor_tracker;
  localparam int unsigned COORD_TOP  = (1 << COORD_BITS_DEF) - 1;
  localparam int unsigned JUMP_DEPTH = JUMP_CHARS_DEF;

  int unsigned    row_bound;
  int unsigned    col_bound;
  int unsigned    cur_row;
  int unsigned    cur_col;
  bit [5:0]       codes[JUMP_DEPTH];
  int unsigned    held;
  cursor_report_t reports_due[$];
  int             faults;

  function new();
    row_bound = 0;
    col_bound = 0;
    cur_row   = 0;
    cur_col   = 0;
    held      = 0;
    faults    = 0;
  endfunction

  function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    if (idx == REG_ROW_COUNT) row_bound = value;
    else if (idx == REG_COLUMN_COUNT) col_bound = value;
  endfunction

  function int due_count();
    return reports_due.size();
  endfunction

  // letters -> 0..25, digits -> 26..35, anything else -> -1
  function int char_code(logic [7:0] c);
    if (c >= CHAR_UA && c <= CHAR_UZ) return int'(c - CHAR_UA);
    if (c >= CHAR_LA && c <= CHAR_LZ) return int'(c - CHAR_LA);
    if (c >= CHAR_D0 && c <= CHAR_D9) return int'(c - CHAR_D0) + int'(DIGIT_CODE0);
    return -1;
  endfunction

  function bit parse_ref(output int unsigned r, output int unsigned c);
    int unsigned       n_let;
    int unsigned       n_dig;
    longint unsigned   colv;
    longint unsigned   rowv;
    int unsigned       e;
    bit                over;
    n_let = 0;
    n_dig = 0;
    colv  = 0;
    rowv  = 0;
    over  = 0;
    r     = 0;
    c     = 0;
    for (int i = 0; i < held; i++) begin
      e = codes[i];
      if (e < LETTER_BASE) begin
        n_let++;
        if (!over) begin
          colv = colv * LETTER_BASE + e + 1;
          if (colv > LETTER_LIMIT) over = 1;
        end
      end else begin
        n_dig++;
        rowv = rowv * DIGIT_BASE + (e - int'(DIGIT_CODE0));
        // saturate just past the cursor range
        if (rowv > COORD_TOP + 1) rowv = COORD_TOP + 2;
      end
    end
    if (n_let == 0 || n_dig == 0 || over) return 0;
    if (colv - 1 > COORD_TOP) return 0;
    if (rowv == 0 || rowv - 1 > COORD_TOP) return 0;
    if (row_bound > 0 && rowv - 1 >= row_bound) return 0;
    if (col_bound > 0 && colv - 1 >= col_bound) return 0;
    r = int'(rowv - 1);
    c = int'(colv - 1);
    return 1;
  endfunction

  function void apply_key(logic [2:0] mode, logic [7:0] ch);
    cursor_report_t rep;
    int             code;
    int unsigned    nr;
    int unsigned    nc;
    logic [2:0]     act;
    act = ACT_NONE;
    case (mode)
      MODE_CHAR: begin
        code = char_code(ch);
        if (code >= 0 && held < JUMP_DEPTH) begin
          codes[held] = 6'(code);
          held++;
          act = ACT_BUF;
        end
      end
      MODE_UP: begin
        if (cur_row > 0) begin
          cur_row--;
          act = ACT_MOVED;
        end
      end
      MODE_DOWN: begin
        if ((row_bound == 0 || cur_row + 1 < row_bound) && cur_row < COORD_TOP) begin
          cur_row++;
          act = ACT_MOVED;
        end
      end
      MODE_LEFT: begin
        if (cur_col > 0) begin
          cur_col--;
          act = ACT_MOVED;
        end
      end
      MODE_RIGHT: begin
        if ((col_bound == 0 || cur_col + 1 < col_bound) && cur_col < COORD_TOP) begin
          cur_col++;
          act = ACT_MOVED;
        end
      end
      MODE_ENTER: begin
        if (held > 0) begin
          if (parse_ref(nr, nc)) begin
            cur_row = nr;
            cur_col = nc;
            act = ACT_JUMPED;
          end
          held = 0;
        end else begin
          act = ACT_ENTER;
        end
      end
      MODE_ESC: act = ACT_DISARM;
      MODE_BKSP: begin
        if (held > 0) begin
          held--;
          act = ACT_BUF;
        end
      end
      default: ;
    endcase
    rep.action = act;
    rep.row    = 16'(cur_row);
    rep.col    = 16'(cur_col);
    rep.held   = 4'(held);
    reports_due.push_back(rep);
  endfunction

  function void check_report(cursor_report_t got);
    cursor_report_t want;
    if (reports_due.size() == 0) begin
      $display("%0t: result with no request pending: action %0d row %0d col %0d len %0d",
               $time, got.action, got.row, got.col, got.held);
      faults++;
      return;
    end
    want = reports_due.pop_front();
    if (got.action !== want.action) begin
      $display("%0t: action mismatch: expected %0d, got %0d", $time, want.action, got.action);
      faults++;
    end
    if (got.row !== want.row) begin
      $display("%0t: cursor_row mismatch: expected %0d, got %0d", $time, want.row, got.row);
      faults++;
    end
    if (got.col !== want.col) begin
      $display("%0t: cursor_col mismatch: expected %0d, got %0d", $time, want.col, got.col);
      faults++;
    end
    if (got.held !== want.held) begin
      $display("%0t: pending_length mismatch: expected %0d, got %0d",
               $time, want.held, got.held);
      faults++;
    end
  endfunction
endclass

module grid_cursor_jump_navigator_tb;
  localparam int unsigned COORD_TOP = (1 << COORD_BITS_DEF) - 1;

  logic clk;
  logic rst_n;

  gcj_in_if                  in_bus();
  gcj_out_if #(.COORD_BITS(16), .LEN_W(4)) out_bus();
  gcj_cfg_if                 cfg_bus();

  grid_cursor_jump_navigator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  cursor_tracker book = new();
  bit            key_gaps;
  bit            result_stalls;
  int            keys_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall bursts, sampled at the rising edge
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (result_stalls && $urandom_range(0, 5) == 0) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_bus.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      book.check_report('{out_bus.action, out_bus.cursor_row, out_bus.cursor_col,
                          out_bus.pending_length});
  end

  task automatic press_key(input logic [2:0] mode, input logic [7:0] ch);
    @(negedge clk);
    if (key_gaps && $urandom_range(0, 6) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.mode  = mode;
    in_bus.ch    = ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    book.apply_key(mode, ch);
    keys_sent++;
  endtask

  // drop the request line and wait for every report to come back
  task automatic settle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (book.due_count() > 0) @(posedge clk);
  endtask

  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    book.set_bound(idx, value);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [7:0] random_alnum();
    case ($urandom_range(0, 2))
      0:       return CHAR_UA + 8'($urandom_range(0, 25));
      1:       return CHAR_LA + 8'($urandom_range(0, 25));
      default: return CHAR_D0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // bijective base-26 column name, A = 0
  function automatic string letters_of(int unsigned col);
    string       s;
    int unsigned n;
    s = "";
    n = col + 1;
    while (n > 0) begin
      n--;
      s = $sformatf("%c%s", CHAR_UA + 8'(n % LETTER_BASE), s);
      n = n / LETTER_BASE;
    end
    return s;
  endfunction

  function automatic string interleave(string a, string b);
    string r;
    int    i;
    int    j;
    r = "";
    i = 0;
    j = 0;
    while (i < a.len() || j < b.len()) begin
      if (j >= b.len() || (i < a.len() && $urandom_range(0, 1))) begin
        r = $sformatf("%s%c", r, a[i]);
        i++;
      end else begin
        r = $sformatf("%s%c", r, b[j]);
        j++;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_coord(int unsigned bound);
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 30);
      2: begin
        if (bound >= 2) return bound - 2 + $urandom_range(0, 3);
        return $urandom_range(0, 2);
      end
      3:       return COORD_TOP - 2 + $urandom_range(0, 4);
      4:       return $urandom_range(0, 70000);
      default: return $urandom_range(999990, 1000010);
    endcase
  endfunction

  task automatic type_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= CHAR_UA && c <= CHAR_UZ && $urandom_range(0, 1))
        c = c + (CHAR_LA - CHAR_UA);
      press_key(MODE_CHAR, c);
      if ($urandom_range(0, 24) == 0) begin
        press_key(MODE_CHAR, random_alnum());
        press_key(MODE_BKSP, 8'($urandom));
      end
      if ($urandom_range(0, 30) == 0) press_key(MODE_CHAR, 8'($urandom));
    end
  endtask

  task automatic jump_ref();
    int unsigned row;
    int unsigned col;
    string       cs;
    string       rs;
    col = pick_coord(book.col_bound);
    row = pick_coord(book.row_bound);
    cs  = letters_of(col);
    rs  = $sformatf("%0d", row + 1);
    if ($urandom_range(0, 19) == 0) rs = "0";
    else if ($urandom_range(0, 9) == 0) rs = {"0", rs};
    case ($urandom_range(0, 24))
      0: rs = "";
      1: cs = "";
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0:       type_text({rs, cs});
      1:       type_text(interleave(cs, rs));
      default: type_text({cs, rs});
    endcase
    if ($urandom_range(0, 15) == 0) press_key(MODE_ESC, 8'($urandom));
    if ($urandom_range(0, 15) == 0) press_key(MODE_BKSP, 8'($urandom));
    press_key(MODE_ENTER, 8'($urandom));
  endtask

  task automatic arrow_burst();
    logic [2:0] dir;
    dir = 3'($urandom_range(MODE_UP, MODE_RIGHT));
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) dir = 3'($urandom_range(MODE_UP, MODE_RIGHT));
      press_key(dir, 8'($urandom));
    end
  endtask

  // type 10 to 20 characters, which can overrun the buffer, then either resolve it or erase it
  task automatic long_junk();
    int n;
    n = $urandom_range(10, 20);
    repeat (n) press_key(MODE_CHAR, random_alnum());
    if ($urandom_range(0, 1)) press_key(MODE_ENTER, 8'($urandom));
    else repeat (n) press_key(MODE_BKSP, 8'($urandom));
  endtask

  task automatic random_phase(input int count);
    int stop;
    stop = keys_sent + count;
    while (keys_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: jump_ref();
        5, 6:          arrow_burst();
        7:             press_key(3'($urandom_range(0, 7)), 8'($urandom));
        8:             long_junk();
        default: begin
          case ($urandom_range(0, 2))
            0:       press_key(MODE_ENTER, 8'($urandom));
            1:       press_key(MODE_ESC, 8'($urandom));
            default: press_key(MODE_BKSP, 8'($urandom));
          endcase
        end
      endcase
    end
  endtask

  initial begin
    int unsigned row_set[7];
    int unsigned col_set[7];
    in_bus.valid  = 1'b0;
    in_bus.mode   = MODE_CHAR;
    in_bus.ch     = 8'h00;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_ROW_COUNT;
    cfg_bus.data  = '0;
    key_gaps      = 1'b1;
    result_stalls = 1'b1;
    keys_sent     = 0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_bound(REG_ROW_COUNT, 16'd0);
    write_bound(REG_COLUMN_COUNT, 16'd0);

    // blocked moves at the origin, empty-buffer keys, ignored bytes
    press_key(MODE_UP, 8'hFF);
    press_key(MODE_LEFT, 8'h00);
    press_key(MODE_ENTER, 8'hA5);
    press_key(MODE_ESC, 8'h5A);
    press_key(MODE_BKSP, 8'h30);
    press_key(MODE_CHAR, 8'h00);
    press_key(MODE_CHAR, 8'hFF);
    // jump to the top corner of the cursor range, then push past it
    type_text("CRXP65536");
    press_key(MODE_ENTER, 8'h00);
    press_key(MODE_RIGHT, 8'h00);
    press_key(MODE_DOWN, 8'hFF);
    press_key(MODE_UP, 8'h00);
    // digits before letters; a row of zero
    type_text("9a");
    press_key(MODE_ENTER, 8'h00);
    type_text("z0");
    press_key(MODE_ENTER, 8'h00);
    settle();

    row_set = '{0, 65535, 1, 10, $urandom_range(2, 40), 0, 3000};
    col_set = '{0, 65535, 1, 5, $urandom_range(2, 40), 300, 0};
    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        key_gaps      = 1'b0;
        result_stalls = 1'b0;
      end
      if ($urandom_range(0, 1)) begin
        write_bound(REG_COLUMN_COUNT, 16'(col_set[p]));
        write_bound(REG_ROW_COUNT, 16'(row_set[p]));
      end else begin
        write_bound(REG_ROW_COUNT, 16'(row_set[p]));
        write_bound(REG_COLUMN_COUNT, 16'(col_set[p]));
      end
      random_phase(155);
      settle();
    end

    repeat (40) @(posedge clk);
    if (book.faults == 0 && book.due_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
